@@ hdl/bfga_pkg.sv @@
// Shared types, result codes and default sizes for the best-fit group allocator.
package bfga_pkg;

  localparam int DEF_SLOTS       = 16;
  localparam int DEF_MEMBERS     = 16;
  localparam int DEF_COUNT_WIDTH = 8;

  localparam logic [2:0] KIND_REGISTERED = 3'd0;
  localparam logic [2:0] KIND_PLACED     = 3'd1;
  localparam logic [2:0] KIND_NO_FIT     = 3'd2;
  localparam logic [2:0] KIND_FULL       = 3'd3;
  localparam logic [2:0] KIND_RELEASED   = 3'd4;

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_REQUEST  = 1'b1;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic [7:0] total;
    logic [4:0] members;
    logic       last;
  } result_t;

endpackage

@@ hdl/best_fit_group_allocator_top.sv @@
// Best-fit group allocator: bin table in one memory, scan sequencer and result queue.
//
// The block keeps up to SLOTS bins in one synchronous memory (one read and one
// write port, registered read) plus a flip-flop active flag per bin. A register
// command goes from acceptance straight to the done state. A request reads every
// claimed slot through the single memory read port, one entry per cycle, then
// passes through the drain state to the done state, where the chosen bin is
// written back in the same cycle the results are loaded. Each item yields one or
// two results in a two-entry output queue, the second marked by last. A new item
// is taken once the previous one has been written back; its scan runs while
// earlier results are still draining, and it waits at the end until the queue is
// empty.
module best_fit_group_allocator_top
  import bfga_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int MEMBERS     = DEF_MEMBERS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] min_fill,
  input  logic [7:0] capacity,
  input  logic [7:0] group_size,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [3:0] slot,
  output logic [7:0] total,
  output logic [4:0] members,
  output logic       last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int UW = $clog2(SLOTS + 1);
  localparam int MW = $clog2(MEMBERS + 1);
  localparam int TW = COUNT_WIDTH;
  localparam int VW = (TW > 8) ? TW : 8;
  localparam int EW = 16 + TW + MW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state;
  logic [UW-1:0] slots_used;
  logic [SLOTS-1:0] bin_active;

  logic [EW-1:0] bin_mem [SLOTS];
  logic [EW-1:0] rd_word;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic       cmd_q;
  logic [7:0] min_q;
  logic [7:0] cap_q;
  logic [7:0] gs_q;

  logic [IW-1:0] scan_addr;
  logic          eval_valid;
  logic [IW-1:0] eval_idx;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [VW-1:0] best_over;
  logic [EW-1:0] best_word;

  result_t    res_q [2];
  logic [1:0] out_cnt;

  logic in_acc;
  logic out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Fit test on the entry returned by the memory
  logic [MW-1:0] rd_members;
  logic [TW-1:0] rd_total;
  logic [7:0]    rd_cap;
  logic [VW-1:0] spare;
  logic [VW-1:0] over;
  logic          fit;

  assign rd_members = rd_word[MW-1:0];
  assign rd_total   = rd_word[MW +: TW];
  assign rd_cap     = rd_word[MW+TW +: 8];
  assign spare      = VW'(rd_cap) - VW'(rd_total);
  assign over       = spare - VW'(gs_q);
  assign fit = bin_active[eval_idx] && (rd_members < MW'(MEMBERS)) &&
               (VW'(rd_cap) >= VW'(rd_total)) && (spare >= VW'(gs_q));

  logic [UW-1:0] last_addr;
  assign last_addr = slots_used - 1'b1;

  // Write-back values
  logic [MW-1:0] best_members;
  logic [TW-1:0] best_total;
  logic [7:0]    best_cap;
  logic [7:0]    best_min;
  logic [VW:0]   sum_w;
  logic [TW-1:0] new_total;
  logic [MW-1:0] new_members;
  logic          place_release;
  logic          table_full;
  logic [IW+3:0] best_idx_x;
  logic [UW+3:0] new_idx_x;
  logic [TW+7:0] new_total_x;
  logic [MW+4:0] new_members_x;

  assign best_members  = best_word[MW-1:0];
  assign best_total    = best_word[MW +: TW];
  assign best_cap      = best_word[MW+TW +: 8];
  assign best_min      = best_word[MW+TW+8 +: 8];
  assign sum_w         = (VW+1)'(best_total) + (VW+1)'(gs_q);
  assign new_total     = sum_w[TW-1:0];
  assign new_members   = best_members + 1'b1;
  assign place_release = (VW'(new_total) >= VW'(best_min));
  assign table_full    = (slots_used == UW'(SLOTS));
  assign best_idx_x    = (IW+4)'(best_idx);
  assign new_idx_x     = (UW+4)'(slots_used);
  assign new_total_x   = (TW+8)'(new_total);
  assign new_members_x = (MW+5)'(new_members);

  logic done_fire;
  assign done_fire = (state == ST_DONE) && (out_cnt == 2'd0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx;
    wr_data = {best_min, best_cap, new_total, new_members};
    if (done_fire) begin
      if (cmd_q == CMD_REGISTER) begin
        wr_en   = !table_full;
        wr_addr = slots_used[IW-1:0];
        wr_data = {min_q, cap_q, TW'(0), MW'(0)};
      end else begin
        wr_en = found;
      end
    end
  end

  // Bin memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
    rd_word <= bin_mem[scan_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      eval_valid <= 1'b0;
    end else begin
      eval_valid <= (state == ST_SCAN);
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (cmd == CMD_REQUEST && slots_used != UW'(0)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (UW'(scan_addr) == last_addr) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_DONE;
        ST_DONE: begin
          if (out_cnt == 2'd0) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    eval_idx <= scan_addr;
    if (in_acc) begin
      cmd_q     <= cmd;
      min_q     <= min_fill;
      cap_q     <= capacity;
      gs_q      <= group_size;
      scan_addr <= '0;
    end else if (state == ST_SCAN) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  // Keep the best candidate; strict compare leaves ties at the lowest index
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (in_acc) begin
      found <= 1'b0;
    end else if (eval_valid && fit && (!found || over < best_over)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_valid && fit && (!found || over < best_over)) begin
      best_idx  <= eval_idx;
      best_over <= over;
      best_word <= rd_word;
    end
  end

  // Slot bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      bin_active <= '0;
    end else if (done_fire) begin
      if (cmd_q == CMD_REGISTER) begin
        if (!table_full) begin
          slots_used <= slots_used + 1'b1;
          bin_active[slots_used[IW-1:0]] <= (min_q != 8'd0);
        end
      end else if (found && place_release) begin
        bin_active[best_idx] <= 1'b0;
      end
    end
  end

  // Result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (done_fire) begin
      if (cmd_q == CMD_REGISTER) begin
        out_cnt <= (!table_full && min_q == 8'd0) ? 2'd2 : 2'd1;
      end else begin
        out_cnt <= (found && place_release) ? 2'd2 : 2'd1;
      end
    end else if (out_acc) begin
      out_cnt <= out_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      if (cmd_q == CMD_REGISTER) begin
        if (table_full) begin
          res_q[0] <= '{kind: KIND_FULL, slot: '0, total: '0, members: '0, last: 1'b1};
        end else begin
          res_q[0] <= '{kind: KIND_REGISTERED, slot: new_idx_x[3:0], total: '0,
                        members: '0, last: (min_q != 8'd0)};
          res_q[1] <= '{kind: KIND_RELEASED, slot: new_idx_x[3:0], total: '0,
                        members: '0, last: 1'b1};
        end
      end else if (!found) begin
        res_q[0] <= '{kind: KIND_NO_FIT, slot: '0, total: '0, members: '0, last: 1'b1};
      end else begin
        res_q[0] <= '{kind: KIND_PLACED, slot: best_idx_x[3:0], total: new_total_x[7:0],
                      members: new_members_x[4:0], last: !place_release};
        res_q[1] <= '{kind: KIND_RELEASED, slot: best_idx_x[3:0],
                      total: new_total_x[7:0], members: new_members_x[4:0], last: 1'b1};
      end
    end else if (out_acc) begin
      res_q[0] <= res_q[1];
    end
  end

  assign out_valid = (out_cnt != 2'd0);
  assign kind      = res_q[0].kind;
  assign slot      = res_q[0].slot;
  assign total     = res_q[0].total;
  assign members   = res_q[0].members;
  assign last      = res_q[0].last;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) out_cnt != 2'd3)
    else $error("result queue count out of range");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    out_cnt == 2'd2 |-> !res_q[0].last && res_q[1].last)
    else $error("result pair carries wrong last flags");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_cnt == 2'd1 |-> res_q[0].last)
    else $error("lone result not marked last");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= UW'(SLOTS))
    else $error("slot count beyond table size");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    table_full |=> table_full)
    else $error("full table lost a slot");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the best-fit group allocator top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfga_pkg::*;

  localparam int NSLOT            = DEF_SLOTS;
  localparam int NMEMB            = DEF_MEMBERS;
  localparam int RANDOM_PER_PHASE = 233;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int PLAN_ROWS        = 17;

  typedef struct packed {
    logic       cmd;
    logic [7:0] mf;
    logic [7:0] cap;
    logic [7:0] gs;
    logic       typed;
    logic [2:0] kind;
    logic [3:0] slot;
    logic [7:0] total;
    logic [4:0] members;
  } stim_row_t;

  // Directed rows: slots are claimed in order, so typed slot numbers follow the row order.
  localparam stim_row_t PLAN [PLAN_ROWS] = '{
    '{CMD_REQUEST,  8'd0,   8'd0,   8'd0,   1'b1, KIND_NO_FIT,     4'd0, 8'd0,   5'd0},
    '{CMD_REGISTER, 8'd0,   8'd0,   8'd0,   1'b1, KIND_REGISTERED, 4'd0, 8'd0,   5'd0},
    '{CMD_REQUEST,  8'hff,  8'hff,  8'd0,   1'b1, KIND_NO_FIT,     4'd0, 8'd0,   5'd0},
    '{CMD_REGISTER, 8'd255, 8'd255, 8'hff,  1'b1, KIND_REGISTERED, 4'd1, 8'd0,   5'd0},
    '{CMD_REQUEST,  8'd0,   8'd0,   8'd255, 1'b1, KIND_PLACED,     4'd1, 8'd255, 5'd1},
    '{CMD_REGISTER, 8'd200, 8'd100, 8'd0,   1'b1, KIND_REGISTERED, 4'd2, 8'd0,   5'd0},
    '{CMD_REGISTER, 8'd50,  8'd60,  8'd0,   1'b1, KIND_REGISTERED, 4'd3, 8'd0,   5'd0},
    '{CMD_REQUEST,  8'd0,   8'd0,   8'd10,  1'b0, KIND_PLACED,     4'd0, 8'd0,   5'd0},
    '{CMD_REQUEST,  8'd0,   8'd0,   8'd255, 1'b1, KIND_NO_FIT,     4'd0, 8'd0,   5'd0},
    '{CMD_REQUEST,  8'd0,   8'd0,   8'd0,   1'b0, KIND_PLACED,     4'd0, 8'd0,   5'd0},
    '{CMD_REQUEST,  8'd0,   8'd0,   8'd45,  1'b0, KIND_PLACED,     4'd0, 8'd0,   5'd0},
    '{CMD_REGISTER, 8'd8,   8'd8,   8'd0,   1'b1, KIND_REGISTERED, 4'd4, 8'd0,   5'd0},
    '{CMD_REQUEST,  8'd0,   8'd0,   8'd8,   1'b0, KIND_PLACED,     4'd0, 8'd0,   5'd0},
    '{CMD_REGISTER, 8'd255, 8'd40,  8'd0,   1'b1, KIND_REGISTERED, 4'd5, 8'd0,   5'd0},
    '{CMD_REGISTER, 8'd255, 8'd40,  8'd0,   1'b1, KIND_REGISTERED, 4'd6, 8'd0,   5'd0},
    '{CMD_REQUEST,  8'd0,   8'd0,   8'd30,  1'b0, KIND_PLACED,     4'd0, 8'd0,   5'd0},
    '{CMD_REQUEST,  8'd0,   8'd0,   8'd30,  1'b0, KIND_PLACED,     4'd0, 8'd0,   5'd0}
  };

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic       cmd        = CMD_REGISTER;
  logic [7:0] min_fill   = '0;
  logic [7:0] capacity   = '0;
  logic [7:0] group_size = '0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [2:0] kind;
  logic [3:0] slot;
  logic [7:0] total;
  logic [4:0] members;
  logic       last;

  // Allocation state as the block should hold it.
  logic [4:0] claimed;
  logic [7:0] bin_floor  [NSLOT];
  logic [7:0] bin_cap    [NSLOT];
  logic [7:0] bin_sum    [NSLOT];
  logic [4:0] bin_groups [NSLOT];
  logic       bin_live   [NSLOT];

  result_t outcomes_due [$];

  int errors        = 0;
  int results_seen  = 0;
  int items_sent    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int kind_seen [5] = '{default: 0};
  bit pressure_go   = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left     = 0;

  best_fit_group_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .min_fill  (min_fill),
    .capacity  (capacity),
    .group_size(group_size),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .slot      (slot),
    .total     (total),
    .members   (members),
    .last      (last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               outcomes_due.size());
      $display("best_fit_group_allocator_top test failed");
      $finish;
    end
  end

  function automatic result_t outcome(input logic [2:0] k, input int s, input int t,
                                      input int m);
    result_t r;
    r.kind    = k;
    r.slot    = s[3:0];
    r.total   = t[7:0];
    r.members = m[4:0];
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic release_if_reached(input int s);
    if (bin_sum[s] >= bin_floor[s]) begin
      outcomes_due.push_back(outcome(KIND_RELEASED, s, bin_sum[s], bin_groups[s]));
      bin_live[s] = 1'b0;
    end
  endtask

  // Work out the results of one accepted item; first_pos marks where they start.
  task automatic forecast_allocation(input logic c, input logic [7:0] mf, input logic [7:0] cap,
                                     input logic [7:0] gs, output int first_pos);
    int s;
    int i;
    int best;
    int best_over;
    int spare;
    result_t tail;
    first_pos = outcomes_due.size();
    best = -1;
    best_over = 0;
    if (c == CMD_REGISTER) begin
      if (claimed >= NSLOT) begin
        outcomes_due.push_back(outcome(KIND_FULL, 0, 0, 0));
      end else begin
        s = int'(claimed);
        claimed = claimed + 1'b1;
        bin_floor[s]  = mf;
        bin_cap[s]    = cap;
        bin_sum[s]    = '0;
        bin_groups[s] = '0;
        bin_live[s]   = 1'b1;
        outcomes_due.push_back(outcome(KIND_REGISTERED, s, 0, 0));
        release_if_reached(s);
      end
    end else begin
      // Tightest fit wins; strict compare keeps the lowest index on a tie.
      for (i = 0; i < claimed; i++) begin
        spare = int'(bin_cap[i]) - int'(bin_sum[i]);
        if (bin_live[i] && bin_groups[i] < NMEMB && spare >= int'(gs) &&
            (best < 0 || spare - int'(gs) < best_over)) begin
          best = i;
          best_over = spare - int'(gs);
        end
      end
      if (best < 0) begin
        outcomes_due.push_back(outcome(KIND_NO_FIT, 0, 0, 0));
      end else begin
        bin_sum[best]    = bin_sum[best] + gs;
        bin_groups[best] = bin_groups[best] + 1'b1;
        outcomes_due.push_back(outcome(KIND_PLACED, best, bin_sum[best], bin_groups[best]));
        release_if_reached(best);
      end
    end
    tail = outcomes_due.pop_back();
    tail.last = 1'b1;
    outcomes_due.push_back(tail);
  endtask

  // Starts and ends at a falling edge; holds the item until the block takes it.
  task automatic offer_item(input logic c, input logic [7:0] mf, input logic [7:0] cap,
                            input logic [7:0] gs, input logic typed, input result_t want);
    int first_pos;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    min_fill   <= mf;
    capacity   <= cap;
    group_size <= gs;
    do @(posedge clk); while (in_stall);
    forecast_allocation(c, mf, cap, gs, first_pos);
    if (typed) begin
      outcomes_due[first_pos].kind    = want.kind;
      outcomes_due[first_pos].slot    = want.slot;
      outcomes_due[first_pos].total   = want.total;
      outcomes_due[first_pos].members = want.members;
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic flag_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= 30)
      $display("mismatch in %s at result %0d: got %0d, expected %0d", field, results_seen, got,
               want);
  endtask

  // Receiver: random stalls, plus one long hold-off to back up the block.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_go && !pressure_done) begin
      out_stall     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        flag_mismatch("kind (nothing expected)", kind, -1);
      end else begin
        want = outcomes_due.pop_front();
        if (kind !== want.kind)       flag_mismatch("kind", kind, want.kind);
        if (slot !== want.slot)       flag_mismatch("slot", slot, want.slot);
        if (total !== want.total)     flag_mismatch("total", total, want.total);
        if (members !== want.members) flag_mismatch("members", members, want.members);
        if (last !== want.last)       flag_mismatch("last", last, want.last);
      end
      if (kind <= KIND_RELEASED) kind_seen[kind]++;
      results_seen++;
    end
  end

  initial begin : stimulus
    int p;
    int n;
    logic c;
    logic [7:0] mf;
    logic [7:0] cap;
    logic [7:0] gs;
    result_t row_want;
    claimed = '0;
    foreach (bin_live[i]) bin_live[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (PLAN[r]) begin
      row_want = outcome(PLAN[r].kind, PLAN[r].slot, PLAN[r].total, PLAN[r].members);
      offer_item(PLAN[r].cmd, PLAN[r].mf, PLAN[r].cap, PLAN[r].gs, PLAN[r].typed, row_want);
    end

    // Phases: no idling (with the long hold-off), sender idle, receiver stall, both.
    for (p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1) ? 59 : (p == 3) ? 32 : 0;
      stall_pct     = (p == 2) ? 59 : (p == 3) ? 32 : 0;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 0 && n == 40) pressure_go = 1'b1;
        mf  = 8'($urandom_range(255));
        cap = 8'($urandom_range(255));
        gs  = 8'($urandom_range(255));
        // Spread new bins over the run; keep probing the full table afterwards.
        if (claimed < NSLOT) c = ($urandom_range(59) == 0) ? CMD_REGISTER : CMD_REQUEST;
        else c = ($urandom_range(24) == 0) ? CMD_REGISTER : CMD_REQUEST;
        if (c == CMD_REGISTER) begin
          if ($urandom_range(7) == 0) mf = '0;
        end else begin
          case ($urandom_range(3))
            0: gs = '0;
            1, 2: gs = 8'($urandom_range(15, 1));
            default: gs = 8'($urandom_range(255));
          endcase
        end
        offer_item(c, mf, cap, gs, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items and checked %0d results over %0d cycles", items_sent, results_seen,
             cycle_count);
    $display("kinds seen: registered %0d, placed %0d, no fit %0d, table full %0d, released %0d",
             kind_seen[KIND_REGISTERED], kind_seen[KIND_PLACED], kind_seen[KIND_NO_FIT],
             kind_seen[KIND_FULL], kind_seen[KIND_RELEASED]);
    if (errors == 0) begin
      $display("best_fit_group_allocator_top test passed");
    end else begin
      $display("best_fit_group_allocator_top test failed");
    end
    $finish;
  end

endmodule
